@@ hdl/symbol_width_repacker_defines.svh @@
// Assertion macros used by the repacker top level.
`ifndef SYMBOL_WIDTH_REPACKER_DEFINES_SVH
`define SYMBOL_WIDTH_REPACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/swr_pkg.sv @@
// Shared types, constants and helpers of the symbol width repacker.
package swr_pkg;

    localparam int SYM_W       = 8;
    localparam int CFG_W       = 4;
    localparam int BUF_W       = 15;
    localparam int CNT_W       = 4;
    localparam int MAX_RESULTS = 8;
    localparam int NOUT_W      = 4;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_BITS     = 2'd0,
        REG_DST_BITS     = 2'd1,
        REG_EMIT_PARTIAL = 2'd2
    } cfg_reg_t;

    // Bit buffer controls: clear wins over shift, shift and load never coincide.
    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } buf_ctrl_t;

    // Zero acts as one, anything above eight acts as eight.
    function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] r;
        r = w;
        if (w == '0)
            r = CFG_W'(1);
        else if (w > CFG_W'(SYM_W))
            r = CFG_W'(SYM_W);
        return r;
    endfunction

    // Low-order mask of w ones, w in 1..8.
    function automatic logic [SYM_W-1:0] low_mask(input logic [CFG_W-1:0] w);
        logic [SYM_W:0] m;
        m = ((SYM_W+1)'(1) << w) - (SYM_W+1)'(1);
        return m[SYM_W-1:0];
    endfunction

endpackage

@@ hdl/swr_bitbuf.sv @@
// Bit buffer: inserts input symbols above the held bits, shifts out one symbol a cycle while shift is set.
module swr_bitbuf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swr_pkg::buf_ctrl_t      ctrl,
    input  logic [swr_pkg::SYM_W-1:0] sym,
    input  logic [swr_pkg::CFG_W-1:0] src_w,
    input  logic [swr_pkg::CFG_W-1:0] dst_w,
    output logic [swr_pkg::BUF_W-1:0] bits,
    output logic [swr_pkg::CNT_W-1:0] count
);
    import swr_pkg::*;

    logic [BUF_W-1:0] bits_reg,  bits_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        bits_next  = bits_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            bits_next  = '0;
            count_next = '0;
        end
        else if (ctrl.shift)
        begin
            // drop one output symbol from the low end
            bits_next  = bits_reg >> dst_w;
            count_next = count_reg - dst_w;
        end
        else if (ctrl.load)
        begin
            // place the new symbol above the held bits
            bits_next  = bits_reg | (BUF_W'(sym) << count_reg);
            count_next = count_reg + src_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            bits_reg  <= bits_next;
            count_reg <= count_next;
        end
    end

    assign bits  = bits_reg;
    assign count = count_reg;

endmodule

@@ hdl/symbol_width_repacker.sv @@
// Symbol width repacker top level: config registers, result sequencing, output register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, in_symbol, in_last   | sink
//  out     | out_valid, out_ready, out_symbol,        | source
//          | run_last, message_end                    |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink
//
// An item is first inserted into the bit buffer; then its results, n of them (0..8), are
// shifted out of the buffer one per cycle while the output register can take them.
// Reset clears the buffer and restores src_bits 8, dst_bits 6, emit_partial 1.
// The output register frees the sequencer, so the next item is taken while the last
// result still waits; a stalled output holds the sequencer at its current result.
// Config writes are taken every cycle.
`include "symbol_width_repacker_defines.svh"

module symbol_width_repacker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [swr_pkg::SYM_W-1:0]     in_symbol,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [swr_pkg::SYM_W-1:0]     out_symbol,
    output logic                          run_last,
    output logic                          message_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swr_pkg::CFG_W-1:0]     cfg_data
);
    import swr_pkg::*;

    logic [CFG_W-1:0]  src_bits_reg, src_bits_next;
    logic [CFG_W-1:0]  dst_bits_reg, dst_bits_next;
    logic              emit_partial_reg, emit_partial_next;

    logic              busy_reg, busy_next;
    logic              last_reg, last_next;
    logic [NOUT_W-1:0] nout_reg, nout_next;

    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_symbol_reg, out_symbol_next;
    logic              run_last_reg, run_last_next;
    logic              message_end_reg, message_end_next;

    logic [CFG_W-1:0]  sw, dw;
    logic [BUF_W-1:0]  bits;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  count_after;
    logic [NOUT_W-1:0] nout_inc;
    buf_ctrl_t         ctrl;
    logic              in_accept, slot_free;
    logic              full, partial_now, any_out, more, emit, finish;

    assign sw        = clamp_width(src_bits_reg);
    assign dw        = clamp_width(dst_bits_reg);
    assign in_ready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    swr_bitbuf u_bitbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .sym   (in_symbol & low_mask(sw)),
        .src_w (sw),
        .dst_w (dw),
        .bits  (bits),
        .count (count)
    );

    always_comb
    begin
        nout_inc    = nout_reg + NOUT_W'(1);
        count_after = count - dw;
        full        = busy_reg && (count >= dw) && (nout_reg < NOUT_W'(MAX_RESULTS));
        partial_now = busy_reg && !full && last_reg && emit_partial_reg
                      && (count != '0) && (nout_reg < NOUT_W'(MAX_RESULTS));
        any_out     = full || partial_now;
        // another result follows the one taken now
        more        = full && (nout_inc < NOUT_W'(MAX_RESULTS))
                      && ((count_after >= dw)
                          || (last_reg && emit_partial_reg && (count_after != '0)));
        emit        = any_out && slot_free;
        finish      = busy_reg && (!any_out || (slot_free && !more));

        ctrl.load   = in_accept;
        ctrl.shift  = emit && full;
        ctrl.clear  = finish && last_reg;
    end

    always_comb
    begin
        src_bits_next     = src_bits_reg;
        dst_bits_next     = dst_bits_reg;
        emit_partial_next = emit_partial_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SRC_BITS:     src_bits_next     = cfg_data;
                REG_DST_BITS:     dst_bits_next     = cfg_data;
                REG_EMIT_PARTIAL: emit_partial_next = cfg_data[0];
                default:          ;
            endcase
        end

        busy_next = busy_reg;
        last_next = last_reg;
        nout_next = nout_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
            last_next = in_last;
            nout_next = '0;
        end
        else
        begin
            if (emit)
                nout_next = nout_inc;
            if (finish)
                busy_next = 1'b0;
        end

        out_valid_next   = out_valid_reg;
        out_symbol_next  = out_symbol_reg;
        run_last_next    = run_last_reg;
        message_end_next = message_end_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_symbol_next  = bits[SYM_W-1:0] & low_mask(dw);
            run_last_next    = !more;
            message_end_next = !more && last_reg;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_bits_reg     <= CFG_W'(8);
            dst_bits_reg     <= CFG_W'(6);
            emit_partial_reg <= 1'b1;
            busy_reg         <= 1'b0;
            last_reg         <= 1'b0;
            nout_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            src_bits_reg     <= src_bits_next;
            dst_bits_reg     <= dst_bits_next;
            emit_partial_reg <= emit_partial_next;
            busy_reg         <= busy_next;
            last_reg         <= last_next;
            nout_reg         <= nout_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_symbol_reg  <= out_symbol_next;
        run_last_reg    <= run_last_next;
        message_end_reg <= message_end_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_symbol  = out_symbol_reg;
    assign run_last    = run_last_reg;
    assign message_end = message_end_reg;

    `SWR_ASSERT_NOW(a_idle_count, clk, rst_n, !busy_reg, count <= CNT_W'(7), "idle bit count above seven")
    `SWR_ASSERT_NOW(a_idle_clean, clk, rst_n, !busy_reg, (bits >> count) == '0, "stale bits above bit count")
    `SWR_ASSERT_NOW(a_end_on_run_last, clk, rst_n, out_valid_reg && message_end_reg, run_last_reg, "message end without run last")
    `SWR_ASSERT_NEXT(a_final_frees, clk, rst_n, emit && !more, !busy_reg, "sequencer still busy after final result")

endmodule
